>>> rtl/core/per_entry_value_history_store_unit_defines.svh
// assertion macros for the per-entry value history store
`ifndef PER_ENTRY_VALUE_HISTORY_STORE_UNIT_DEFINES_SVH
`define PER_ENTRY_VALUE_HISTORY_STORE_UNIT_DEFINES_SVH

`ifndef SYNTH

// property checked on every rising clock edge outside reset
`define PEHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define PEHS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PEHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define PEHS_ASSERT(lbl, clk, rstn, prop, msg)
`define PEHS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define PEHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/core/pehs_pkg.sv
// types and constants shared by the value history store
`default_nettype none
package pehs_pkg;

  localparam int EntriesDef    = 64;
  localparam int HistDepthDef  = 8;
  localparam int ValueWidthDef = 32;

  localparam int EntryW = 6;
  localparam int AgeW   = 4;
  localparam int DataW  = 32;

  localparam logic ActStore = 1'b0;
  localparam logic ActLoad  = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [EntryW-1:0]        entry_index;
    logic signed [DataW-1:0]  new_value;
    logic [AgeW-1:0]          age;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0]  read_value;
    logic                     age_error;
  } out_word_t;

  typedef enum logic [1:0] {
    K_STORE,
    K_LOAD,
    K_ZERO
  } kind_e;

  // classified word handed from front to back
  typedef struct packed {
    kind_e                    kind;
    logic [EntryW-1:0]        entry;
    logic signed [DataW-1:0]  new_value;
    logic [AgeW-1:0]          age;
    logic                     age_error;
  } q_word_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_HIST
  } state_e;

endpackage
`default_nettype wire

>>> rtl/core/pehs_front.sv
// front end: accepts input words, classifies them and queues them for the back end
`default_nettype none
`include "per_entry_value_history_store_unit_defines.svh"
module pehs_front #(
  parameter int Entries   = pehs_pkg::EntriesDef,
  parameter int HistDepth = pehs_pkg::HistDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire pehs_pkg::in_word_t in_word_i,
  output      logic              q_valid_o,
  output      pehs_pkg::q_word_t q_word_o,
  input  wire logic              q_pop_i
);
  import pehs_pkg::*;

  q_word_t     cls_word;
  logic        cls_keep;
  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  q_word_t     slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  // classify
  always_comb begin
    cls_word           = '0;
    cls_word.entry     = in_word_i.entry_index;
    cls_word.new_value = in_word_i.new_value;
    cls_word.age       = in_word_i.age;
    cls_keep           = 1'b1;
    if (in_word_i.action == ActStore) begin
      cls_word.kind = K_STORE;
      // store to an entry beyond the table is dropped
      if (32'(in_word_i.entry_index) >= 32'(Entries)) begin
        cls_keep = 1'b0;
      end
    end else if (32'(in_word_i.age) > 32'(HistDepth)) begin
      cls_word.kind      = K_ZERO;
      cls_word.age_error = 1'b1;
    end else if (32'(in_word_i.entry_index) >= 32'(Entries)) begin
      cls_word.kind = K_ZERO;
    end else begin
      cls_word.kind = K_LOAD;
    end
  end

  assign full       = (cnt_q == 2'd2);
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && cls_keep;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = slot_q[rd_ptr_q];
  assign pop        = q_valid_o && q_pop_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls_word;
    end
  end

  `PEHS_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")
  `PEHS_ASSERT_IMPLY(a_no_push_full, clk_i, rst_ni, full, !push, "push into full queue")
  `PEHS_ASSERT_IMPLY(a_ptr_match, clk_i, rst_ni, cnt_q == 2'd0 || cnt_q == 2'd2,
                     wr_ptr_q == rd_ptr_q, "queue pointers disagree with count")

endmodule
`default_nettype wire

>>> rtl/core/pehs_back.sv
// back end: entry memories, history ring memory, sequencer and output register
`default_nettype none
`include "per_entry_value_history_store_unit_defines.svh"
module pehs_back #(
  parameter int Entries    = pehs_pkg::EntriesDef,
  parameter int HistDepth  = pehs_pkg::HistDepthDef,
  parameter int ValueWidth = pehs_pkg::ValueWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire pehs_pkg::q_word_t  q_word_i,
  output      logic               q_pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      pehs_pkg::out_word_t out_word_o
);
  import pehs_pkg::*;

  localparam int AW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int PW  = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int CW  = $clog2(HistDepth + 1);
  localparam int MW  = PW + CW;
  localparam int HN  = Entries * HistDepth;
  localparam int HAW = (HN > 1) ? $clog2(HN) : 1;
  localparam int SW  = AgeW + 1;

  state_e            state_q, state_d;
  q_word_t           itm_q;
  logic [AW-1:0]     clr_idx_q, clr_idx_d;

  logic [ValueWidth-1:0] cur_mem  [Entries];
  logic [MW-1:0]         meta_mem [Entries];
  logic [ValueWidth-1:0] hist_mem [HN];

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ValueWidth-1:0] cur_rd_q;
  logic [MW-1:0]         meta_rd_q;
  logic                  hist_rd_en;
  logic [HAW-1:0]        hist_rd_addr;
  logic [ValueWidth-1:0] hist_rd_q;

  logic                  ent_we;
  logic [AW-1:0]         ent_waddr;
  logic [ValueWidth-1:0] cur_wdata;
  logic [MW-1:0]         meta_wdata;
  logic                  hist_we;
  logic [HAW-1:0]        hist_waddr;

  logic [AW-1:0]         itm_addr;
  logic [PW-1:0]         pos;
  logic [CW-1:0]         fill;
  logic [PW-1:0]         new_pos;
  logic [CW-1:0]         new_fill;
  logic [SW-1:0]         age_sum;
  logic [PW-1:0]         age_pos;
  logic [HAW-1:0]        row_base;

  logic                  out_load;
  out_word_t             out_next;
  logic                  out_valid_q;
  out_word_t             out_word_q;

  assign itm_addr = AW'(itm_q.entry);
  assign pos      = meta_rd_q[MW-1:CW];
  assign fill     = meta_rd_q[CW-1:0];
  assign new_pos  = (pos == '0) ? PW'(HistDepth - 1) : pos - PW'(1);
  assign new_fill = (fill == CW'(HistDepth)) ? fill : fill + CW'(1);
  assign row_base = HAW'(itm_addr) * HAW'(HistDepth);

  // ring slot of age h is (pos + h - 1) mod depth
  always_comb begin
    age_sum = SW'(pos) + SW'(itm_q.age) - SW'(1);
    if (age_sum >= SW'(HistDepth)) begin
      age_sum = age_sum - SW'(HistDepth);
    end
    age_pos = PW'(age_sum);
  end

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    q_pop_o      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = AW'(q_word_i.entry);
    hist_rd_en   = 1'b0;
    hist_rd_addr = row_base + HAW'(age_pos);
    ent_we       = 1'b0;
    ent_waddr    = itm_addr;
    cur_wdata    = ValueWidth'(itm_q.new_value);
    meta_wdata   = {new_pos, new_fill};
    hist_we      = 1'b0;
    hist_waddr   = row_base + HAW'(new_pos);
    out_load     = 1'b0;
    out_next     = '0;
    case (state_q)
      ST_CLEAR: begin
        ent_we     = 1'b1;
        ent_waddr  = clr_idx_q;
        cur_wdata  = '0;
        meta_wdata = '0;
        clr_idx_d  = clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(Entries - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_word_i.kind)
            K_STORE: begin
              q_pop_o = 1'b1;
              rd_en   = 1'b1;
              state_d = ST_READ;
            end
            K_LOAD: begin
              if (!out_valid_q) begin
                q_pop_o = 1'b1;
                rd_en   = 1'b1;
                state_d = ST_READ;
              end
            end
            default: begin
              if (!out_valid_q) begin
                q_pop_o            = 1'b1;
                out_load           = 1'b1;
                out_next.age_error = q_word_i.age_error;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        if (itm_q.kind == K_STORE) begin
          ent_we  = 1'b1;
          hist_we = 1'b1;
        end else if (itm_q.age == '0) begin
          out_load            = 1'b1;
          out_next.read_value = DataW'(signed'(cur_rd_q));
        end else if (32'(itm_q.age) <= 32'(fill)) begin
          hist_rd_en = 1'b1;
          state_d    = ST_HIST;
        end else begin
          // slot never written since reset
          out_load = 1'b1;
        end
      end
      ST_HIST: begin
        out_load            = 1'b1;
        out_next.read_value = DataW'(signed'(hist_rd_q));
        state_d             = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      itm_q <= q_word_i;
    end
    if (out_load) begin
      out_word_q <= out_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      cur_mem[ent_waddr]  <= cur_wdata;
      meta_mem[ent_waddr] <= meta_wdata;
    end
    if (rd_en) begin
      cur_rd_q  <= cur_mem[rd_addr];
      meta_rd_q <= meta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= cur_rd_q;
    end
    if (hist_rd_en) begin
      hist_rd_q <= hist_mem[hist_rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `PEHS_ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q,
                     "output register overwritten")
  `PEHS_ASSERT_IMPLY(a_no_pop_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !q_pop_o,
                     "queue popped during clearing pass")
  `PEHS_ASSERT_NEXT(a_hist_done, clk_i, rst_ni, state_q == ST_HIST,
                    out_valid_q && state_q == ST_IDLE, "history read gave no result")

endmodule
`default_nettype wire

>>> rtl/core/per_entry_value_history_store_unit.sv
// Per-entry value history store: top level.
//
// Input channel in_valid_i/in_ready_o carries one word: action, entry_index,
// new_value, age. A store (action 0) sets the entry's current value and pushes
// the old one into the entry's history ring; it gives no result. A load
// (action 1) returns one word on out_valid_o/out_ready_i: the current value
// for age 0, the value from age stores ago otherwise, and zero with
// age_error set when age is above the history depth.
// A rejected load is answered from the queue head, an age 0 load after the
// registered read of the entry memory, and a history read after the registered
// reads of the entry memory and then the history ring memory. The back end
// takes no new item from the queue until it has finished with the last one.
// A two-word queue sits between the input and the back end.
// After reset the back end clears every entry of the entry memory in turn;
// up to two words are queued meanwhile and then in_ready_o drops.
// While the receiver holds out_ready_i low the result stays in the output
// register; stores keep draining, loads wait for the register to empty.
`default_nettype none
module per_entry_value_history_store_unit #(
  parameter int Entries    = pehs_pkg::EntriesDef,
  parameter int HistDepth  = pehs_pkg::HistDepthDef,
  parameter int ValueWidth = pehs_pkg::ValueWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire pehs_pkg::in_word_t  in_word_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      pehs_pkg::out_word_t out_word_o
);
  import pehs_pkg::*;

  logic    q_valid;
  q_word_t q_word;
  logic    q_pop;

  pehs_front #(
    .Entries   (Entries),
    .HistDepth (HistDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_word_o   (q_word),
    .q_pop_i    (q_pop)
  );

  pehs_back #(
    .Entries    (Entries),
    .HistDepth  (HistDepth),
    .ValueWidth (ValueWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the per-entry value history store
module tb;
  import pehs_pkg::*;

  localparam int NumEntries  = EntriesDef;
  localparam int Depth       = HistDepthDef;
  localparam int SlotW       = $clog2(Depth);
  localparam int MaxWait     = 12;
  localparam int SeqTarget   = 760;
  localparam int TotalTarget = 960;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 250000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // shadow copy of the table
  logic [DataW-1:0] cur_value  [NumEntries];
  logic [DataW-1:0] past_value [NumEntries][Depth];
  logic [SlotW-1:0] head_slot  [NumEntries];

  out_word_t pending_reads[$];

  int n_sent       = 0;
  int n_stores     = 0;
  int n_loads      = 0;
  int n_age_errors = 0;
  int fail_count   = 0;
  int cycle_count  = 0;
  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;

  per_entry_value_history_store_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("per_entry_value_history_store_unit regression: fail");
      $finish;
    end
  end

  // update the shadow table for one accepted word, queue the read it returns
  function automatic void record_access(in_word_t w);
    out_word_t        r;
    logic [SlotW-1:0] slot;
    r = '0;
    if (w.action == ActStore) begin
      slot = head_slot[w.entry_index] - SlotW'(1);
      head_slot[w.entry_index] = slot;
      past_value[w.entry_index][slot] = cur_value[w.entry_index];
      cur_value[w.entry_index] = w.new_value;
      n_stores++;
    end else begin
      if (32'(w.age) > Depth) begin
        r.age_error = 1'b1;
        n_age_errors++;
      end else if (w.age == '0) begin
        r.read_value = cur_value[w.entry_index];
      end else begin
        slot = head_slot[w.entry_index] + SlotW'(w.age - 1);
        r.read_value = past_value[w.entry_index][slot];
      end
      pending_reads.push_back(r);
      n_loads++;
    end
  endfunction

  function automatic in_word_t make_word(logic act, int entry, logic [DataW-1:0] value,
                                         int age);
    in_word_t w;
    w.action      = act;
    w.entry_index = EntryW'(entry);
    w.new_value   = value;
    w.age         = AgeW'(age);
    return w;
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '1;
      3: v = '0;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    record_access(w);
    n_sent++;
  endtask

  // drop valid and let every outstanding read come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // untouched entries read back zero at age 0, an inner age and the full depth
  task automatic test_reset_state();
    send_word(make_word(ActLoad, 0, 32'h1234_5678, 0));
    send_word(make_word(ActLoad, NumEntries - 1, '1, Depth));
    send_word(make_word(ActLoad, 37, '0, 4));
    settle();
  endtask

  task automatic test_field_extremes();
    send_word(make_word(ActStore, 0, 32'h8000_0000, 15));
    send_word(make_word(ActStore, 0, 32'h7fff_ffff, 0));
    send_word(make_word(ActStore, NumEntries - 1, 32'hffff_ffff, 9));
    send_word(make_word(ActStore, NumEntries - 1, 32'h5555_aaaa, 6));
    send_word(make_word(ActLoad, 0, 32'hffff_ffff, 0));
    send_word(make_word(ActLoad, 0, '0, 1));
    send_word(make_word(ActLoad, 0, '0, 2));
    send_word(make_word(ActLoad, NumEntries - 1, 32'haaaa_5555, 1));
    send_word(make_word(ActLoad, NumEntries - 1, '0, Depth));
    // ages past the ring depth
    send_word(make_word(ActLoad, 0, '0, Depth + 1));
    send_word(make_word(ActLoad, NumEntries - 1, '1, 15));
    settle();
  endtask

  // runs of stores to one entry then reads across its ring, wrapping often
  task automatic test_history_sequences();
    int hot [4];
    int entry;
    int age;
    foreach (hot[i]) hot[i] = $urandom_range(0, NumEntries - 1);
    while (n_sent < SeqTarget) begin
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      entry = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)]
                                          : $urandom_range(0, NumEntries - 1);
      repeat ($urandom_range(1, 2 * Depth + 1))
        send_word(make_word(ActStore, entry, pick_value(), $urandom_range(0, 15)));
      repeat ($urandom_range(1, Depth + 2)) begin
        age = ($urandom_range(0, 6) != 0) ? $urandom_range(0, Depth)
                                          : $urandom_range(Depth + 1, 15);
        send_word(make_word(ActLoad, entry, $urandom, age));
      end
      // stray word to a random entry
      if ($urandom_range(0, 2) == 0)
        send_word(make_word(1'($urandom_range(0, 1)), $urandom_range(0, NumEntries - 1),
                            $urandom, $urandom_range(0, 15)));
    end
    settle();
  endtask

  task automatic test_random_traffic();
    while (n_sent < TotalTarget) begin
      if (n_sent % 40 == 0) begin
        sender_steady   = ($urandom_range(0, 2) == 0);
        receiver_steady = ($urandom_range(0, 2) == 0);
      end
      send_word(make_word(1'($urandom_range(0, 1)), $urandom_range(0, NumEntries - 1),
                          pick_value(), $urandom_range(0, 15)));
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    settle();
  endtask

  initial begin : result_check
    int        stall;
    out_word_t want;
    @(posedge rst_ni);
    forever begin
      stall = receiver_steady ? 0 : $urandom_range(0, MaxWait);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (out_valid !== 1'b1);
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected word read_value=%h age_error=%b", $time,
                 out_word.read_value, out_word.age_error);
        fail_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_word.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   want.read_value, out_word.read_value);
          fail_count++;
        end
        if (out_word.age_error !== want.age_error) begin
          $display("%0t: age_error expected %b actual %b", $time,
                   want.age_error, out_word.age_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int e = 0; e < NumEntries; e++) begin
      cur_value[e] = '0;
      head_slot[e] = '0;
      for (int s = 0; s < Depth; s++) past_value[e][s] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_field_extremes();
    test_history_sequences();
    test_random_traffic();
    $display("covered %0d words: %0d stores, %0d loads, %0d of them with age past depth",
             n_sent, n_stores, n_loads, n_age_errors);
    $display("finished after %0d cycles with %0d mismatches", cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("per_entry_value_history_store_unit regression: pass");
    end else begin
      $display("per_entry_value_history_store_unit regression: fail");
    end
    $finish;
  end

endmodule
